// ===== src/itb_pkg.sv =====
// ----------------------------------------------------------------------------
// itb_pkg
// Shared constants and helpers for the integer time bucket pipeline.
// ----------------------------------------------------------------------------
package itb_pkg;

    localparam int DATA_WIDTH = 64;

    // result status codes
    localparam logic [1:0] ERR_OK     = 2'd0;
    localparam logic [1:0] ERR_PERIOD = 2'd1;
    localparam logic [1:0] ERR_RANGE  = 2'd2;

    // width mode codes; anything else selects 64 bits
    localparam logic [1:0] MODE_16 = 2'd0;
    localparam logic [1:0] MODE_32 = 2'd1;
    localparam logic [1:0] MODE_64 = 2'd2;

    // register indexes
    localparam logic [1:0] REG_PERIOD = 2'd0;
    localparam logic [1:0] REG_OFFSET = 2'd1;
    localparam logic [1:0] REG_MODE   = 2'd2;

    // left/arith-right shift that sign-extends from the selected width
    function automatic int ext_shift(logic [1:0] mode, int dw);
        int w;
        begin
            case (mode)
                MODE_16: w = 16;
                MODE_32: w = 32;
                default: w = 64;
            endcase
            if (w > dw)
            begin
                w = dw;
            end
            return dw - w;
        end
    endfunction

endpackage

// ===== src/itb_front.sv =====
// ----------------------------------------------------------------------------
// itb_front
// Input stage: width selection, sign extension, magnitudes for the dividers.
// ----------------------------------------------------------------------------
module itb_front #(
    parameter int W = itb_pkg::DATA_WIDTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                adv,
    input  logic                in_v,
    input  logic [63:0]         time_value,
    input  logic [63:0]         period_cfg,
    input  logic [63:0]         offset_cfg,
    input  logic [1:0]          mode_cfg,
    output logic                v_reg,
    output logic signed [W-1:0] t_reg,
    output logic signed [W-1:0] off_reg,
    output logic [W-1:0]        p_reg,
    output logic [W-1:0]        at_reg,
    output logic [W-1:0]        ao_reg,
    output logic                inv_reg
);
    localparam int SW = $clog2(W + 1);

    logic [SW-1:0]        sh;
    logic signed [W-1:0]  t_next;
    logic signed [W-1:0]  off_next;
    logic signed [W-1:0]  p_s;

    // sign-extend from the selected width
    always_comb
    begin
        sh       = SW'(itb_pkg::ext_shift(mode_cfg, W));
        t_next   = $signed(time_value[W-1:0] << sh) >>> sh;
        off_next = $signed(offset_cfg[W-1:0] << sh) >>> sh;
        p_s      = $signed(period_cfg[W-1:0] << sh) >>> sh;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (adv)
        begin
            v_reg <= in_v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t_reg   <= t_next;
            off_reg <= off_next;
            p_reg   <= p_s;
            inv_reg <= (p_s <= 0);
            at_reg  <= t_next[W-1] ? W'(-t_next) : t_next;
            ao_reg  <= off_next[W-1] ? W'(-off_next) : off_next;
        end
    end

endmodule

// ===== src/itb_rem_stage.sv =====
// ----------------------------------------------------------------------------
// itb_rem_stage
// One bit of two restoring remainder units (timestamp and offset magnitudes).
// ----------------------------------------------------------------------------
module itb_rem_stage #(
    parameter int W = itb_pkg::DATA_WIDTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                adv,
    input  logic                v_in,
    input  logic signed [W-1:0] t_in,
    input  logic signed [W-1:0] off_in,
    input  logic [W-1:0]        p_in,
    input  logic                inv_in,
    input  logic [W-1:0]        at_in,
    input  logic [W-1:0]        ao_in,
    input  logic [W-1:0]        rt_in,
    input  logic [W-1:0]        ro_in,
    output logic                v_reg,
    output logic signed [W-1:0] t_reg,
    output logic signed [W-1:0] off_reg,
    output logic [W-1:0]        p_reg,
    output logic                inv_reg,
    output logic [W-1:0]        at_reg,
    output logic [W-1:0]        ao_reg,
    output logic [W-1:0]        rt_reg,
    output logic [W-1:0]        ro_reg
);
    logic [W-1:0] rt_sh;
    logic [W-1:0] ro_sh;
    logic [W-1:0] rt_next;
    logic [W-1:0] ro_next;

    // shift in the next dividend bit, subtract the period if it fits
    always_comb
    begin
        rt_sh   = {rt_in[W-2:0], at_in[W-1]};
        ro_sh   = {ro_in[W-2:0], ao_in[W-1]};
        rt_next = (rt_sh >= p_in) ? rt_sh - p_in : rt_sh;
        ro_next = (ro_sh >= p_in) ? ro_sh - p_in : ro_sh;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (adv)
        begin
            v_reg <= v_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t_reg   <= t_in;
            off_reg <= off_in;
            p_reg   <= p_in;
            inv_reg <= inv_in;
            at_reg  <= {at_in[W-2:0], 1'b0};
            ao_reg  <= {ao_in[W-2:0], 1'b0};
            rt_reg  <= rt_next;
            ro_reg  <= ro_next;
        end
    end

endmodule

// ===== src/itb_back.sv =====
// ----------------------------------------------------------------------------
// itb_back
// Two closing stages: offset reduction and range checks, then floor and add.
// ----------------------------------------------------------------------------
module itb_back #(
    parameter int W = itb_pkg::DATA_WIDTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                adv,
    input  logic [1:0]          mode_cfg,
    input  logic                v_in,
    input  logic signed [W-1:0] t_in,
    input  logic signed [W-1:0] off_in,
    input  logic [W-1:0]        p_in,
    input  logic                inv_in,
    input  logic [W-1:0]        rt_in,
    input  logic [W-1:0]        ro_in,
    output logic                out_v_reg,
    output logic [63:0]         bucket_reg,
    output logic [1:0]          err_reg
);
    localparam int SW = $clog2(W + 1);

    logic [SW-1:0]        sh;
    logic signed [W:0]    lo;
    logic signed [W:0]    hi;
    logic signed [W-1:0]  r;
    logic [W-1:0]         tf;
    logic [W-1:0]         rf;
    logic signed [W:0]    d;
    logic signed [W:0]    fm;
    logic signed [W:0]    t_x;
    logic signed [W:0]    r_x;
    logic                 rerr;

    logic                 v1_reg;
    logic signed [W-1:0]  r1_reg;
    logic signed [W:0]    fm1_reg;
    logic signed [W:0]    tp1_reg;
    logic                 inv1_reg;
    logic                 rerr1_reg;

    logic signed [W+1:0]  fl;
    logic [W-1:0]         sum;
    logic signed [W-1:0]  res;
    logic [1:0]           err_next;
    logic [63:0]          bucket_next;

    // limits of the selected width
    always_comb
    begin
        sh = SW'(itb_pkg::ext_shift(mode_cfg, W));
        lo = $signed({1'b1, {W{1'b1}}} << (W[SW-1:0] - sh - 1'b1));
        hi = ~lo;
    end

    // stage 1: signed remainder of the offset, floor remainder of (t - r),
    // range check
    always_comb
    begin
        r    = off_in[W-1] ? W'(-ro_in) : ro_in;
        tf   = (t_in[W-1] && rt_in != '0) ? p_in - rt_in : rt_in;
        rf   = (off_in[W-1] && ro_in != '0) ? p_in - ro_in : ro_in;
        d    = $signed({1'b0, tf}) - $signed({1'b0, rf});
        fm   = (d < 0) ? d + $signed({1'b0, p_in}) : d;
        t_x  = {t_in[W-1], t_in};
        r_x  = {r[W-1], r};
        rerr = ((r > 0) && (t_x < lo + r_x)) || ((r < 0) && (t_x > hi + r_x));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg    <= v_in;
            out_v_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r1_reg    <= r;
            fm1_reg   <= fm;
            tp1_reg   <= t_x - r_x;
            inv1_reg  <= inv_in;
            rerr1_reg <= rerr;
        end
    end

    // stage 2: floor of (t - r), minimum check, add offset back with wrap
    always_comb
    begin
        fl  = {tp1_reg[W], tp1_reg} - {fm1_reg[W], fm1_reg};
        sum = fl[W-1:0] + r1_reg;
        res = $signed(sum << sh) >>> sh;
        if (inv1_reg)
        begin
            err_next = itb_pkg::ERR_PERIOD;
        end
        else if (rerr1_reg || (fl < $signed({lo[W], lo})))
        begin
            err_next = itb_pkg::ERR_RANGE;
        end
        else
        begin
            err_next = itb_pkg::ERR_OK;
        end
        bucket_next = (err_next == itb_pkg::ERR_OK) ? 64'(res) : 64'd0;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            bucket_reg <= bucket_next;
            err_reg    <= err_next;
        end
    end

endmodule

// ===== src/integer_time_bucket.sv =====
// ----------------------------------------------------------------------------
// integer_time_bucket
// Maps each signed timestamp to the start of its offset bucket.
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------
//  in       | in_valid / in_ready  | time_value
//  out      | out_valid/ out_ready | bucket_start, error_code
//  cfg      | cfg_we               | cfg_index, cfg_data
//
// One item per cycle while the output is not stalled; a result passes the input
// stage, the bit-per-stage remainder pipeline (one stage per dividend bit) and
// the two closing stages, each of them registered.
// Reset clears all valid bits and loads period 1, offset 0, 64-bit mode.
// A stall on the output freezes every stage together; nothing is dropped.
// ----------------------------------------------------------------------------
module integer_time_bucket #(
    parameter int DATA_WIDTH = itb_pkg::DATA_WIDTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [63:0] time_value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] bucket_start,
    output logic [1:0]  error_code,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);
    localparam int W = DATA_WIDTH;

    logic [63:0] period_reg;
    logic [63:0] offset_reg;
    logic [1:0]  mode_reg;
    logic        adv;

    logic                v_s   [0:W];
    logic signed [W-1:0] t_s   [0:W];
    logic signed [W-1:0] off_s [0:W];
    logic [W-1:0]        p_s   [0:W];
    logic                inv_s [0:W];
    logic [W-1:0]        at_s  [0:W];
    logic [W-1:0]        ao_s  [0:W];
    logic [W-1:0]        rt_s  [0:W];
    logic [W-1:0]        ro_s  [0:W];

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= 64'd1;
            offset_reg <= 64'd0;
            mode_reg   <= itb_pkg::MODE_64;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                itb_pkg::REG_PERIOD: period_reg <= cfg_data;
                itb_pkg::REG_OFFSET: offset_reg <= cfg_data;
                itb_pkg::REG_MODE:   mode_reg   <= cfg_data[1:0];
                default:             ;
            endcase
        end
    end

    // whole pipe moves when the output slot is free or being taken
    assign adv      = !out_valid || out_ready;
    assign in_ready = adv;

    itb_front #(.W(W)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .in_v       (in_valid),
        .time_value (time_value),
        .period_cfg (period_reg),
        .offset_cfg (offset_reg),
        .mode_cfg   (mode_reg),
        .v_reg      (v_s[0]),
        .t_reg      (t_s[0]),
        .off_reg    (off_s[0]),
        .p_reg      (p_s[0]),
        .at_reg     (at_s[0]),
        .ao_reg     (ao_s[0]),
        .inv_reg    (inv_s[0])
    );

    assign rt_s[0] = '0;
    assign ro_s[0] = '0;

    // one remainder stage per dividend bit
    for (genvar i = 0; i < W; i++)
    begin : g_rem
        itb_rem_stage #(.W(W)) u_stage (
            .clk     (clk),
            .rst_n   (rst_n),
            .adv     (adv),
            .v_in    (v_s[i]),
            .t_in    (t_s[i]),
            .off_in  (off_s[i]),
            .p_in    (p_s[i]),
            .inv_in  (inv_s[i]),
            .at_in   (at_s[i]),
            .ao_in   (ao_s[i]),
            .rt_in   (rt_s[i]),
            .ro_in   (ro_s[i]),
            .v_reg   (v_s[i+1]),
            .t_reg   (t_s[i+1]),
            .off_reg (off_s[i+1]),
            .p_reg   (p_s[i+1]),
            .inv_reg (inv_s[i+1]),
            .at_reg  (at_s[i+1]),
            .ao_reg  (ao_s[i+1]),
            .rt_reg  (rt_s[i+1]),
            .ro_reg  (ro_s[i+1])
        );
    end

    itb_back #(.W(W)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .mode_cfg   (mode_reg),
        .v_in       (v_s[W]),
        .t_in       (t_s[W]),
        .off_in     (off_s[W]),
        .p_in       (p_s[W]),
        .inv_in     (inv_s[W]),
        .rt_in      (rt_s[W]),
        .ro_in      (ro_s[W]),
        .out_v_reg  (out_valid),
        .bucket_reg (bucket_start),
        .err_reg    (error_code)
    );

endmodule

// ===== tb/tb_integer_time_bucket.sv =====
// ----------------------------------------------------------------------------
// tb_integer_time_bucket
// Self-checking bench for the integer time bucket block: drives timestamps
// under a series of period, offset and width settings, predicts each bucket
// start and status in a scoreboard, and compares every result in order.
// ----------------------------------------------------------------------------
module tb_integer_time_bucket;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY   = itb_pkg::DATA_WIDTH + 3;
    localparam int IDLE_LIMIT = 5000;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic [63:0] bucket;
        logic [1:0]  status;
    } bucket_result_t;

    // ------------------------------------------------------------------------
    // Scoreboard: own copy of the registers, queue of expected buckets
    // ------------------------------------------------------------------------
    class bucket_scoreboard;
        logic [63:0]    period;
        logic [63:0]    offset;
        logic [1:0]     mode;
        bucket_result_t pending[$];
        int             errors;

        function new();
            period = 64'd1;
            offset = 64'd0;
            mode   = itb_pkg::MODE_64;
            errors = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [63:0] data);
            case (idx)
                itb_pkg::REG_PERIOD: period = data;
                itb_pkg::REG_OFFSET: offset = data;
                itb_pkg::REG_MODE:   mode   = data[1:0];
                default:    ;   // unmapped index is dropped
            endcase
        endfunction

        function longint sext_w(logic [63:0] v, int w);
            logic [63:0] s;
            s = v << (64 - w);
            return $signed(s) >>> (64 - w);
        endfunction

        // work out the bucket for one accepted timestamp
        function void note(logic [63:0] tv);
            int             w;
            longint         lo, hi, p, r, t, q;
            logic [63:0]    sum;
            bit             ok;
            bucket_result_t e;
            w = (mode == itb_pkg::MODE_16) ? 16 : (mode == itb_pkg::MODE_32) ? 32 : 64;
            if (w > itb_pkg::DATA_WIDTH)
            begin
                w = itb_pkg::DATA_WIDTH;
            end
            lo = sext_w(64'd1 << (w - 1), w);
            hi = -(lo + 1);
            p  = sext_w(period, w);
            r  = sext_w(offset, w);
            t  = sext_w(tv, w);
            e.bucket = '0;
            e.status = itb_pkg::ERR_OK;
            ok = 1'b1;
            if (p <= 0)
            begin
                e.status = itb_pkg::ERR_PERIOD;
                ok = 1'b0;
            end
            if (ok && r != 0)
            begin
                r = r % p;
                // offset would push the timestamp past the range
                if ((r > 0 && t < lo + r) || (r < 0 && t > hi + r))
                begin
                    e.status = itb_pkg::ERR_RANGE;
                    ok = 1'b0;
                end
                else
                begin
                    t = t - r;
                end
            end
            if (ok)
            begin
                q = (t / p) * p;
                // floor step for negatives; may fall below the minimum
                if (t < 0 && (t % p) != 0)
                begin
                    if (q < lo + p)
                    begin
                        e.status = itb_pkg::ERR_RANGE;
                        ok = 1'b0;
                    end
                    else
                    begin
                        q = q - p;
                    end
                end
            end
            if (ok)
            begin
                sum = q + r;    // wraps in the width
                e.bucket = sext_w(sum, w);
            end
            pending.push_back(e);
        endfunction

        task report(string msg);
            $display("MISMATCH @%0t: %s", $realtime, msg);
            errors++;
        endtask

        task check(logic [63:0] bucket, logic [1:0] status);
            bucket_result_t e;
            if (pending.size() == 0)
            begin
                report($sformatf("unexpected item bucket=%h status=%0d", bucket, status));
            end
            else
            begin
                e = pending.pop_front();
                if (bucket !== e.bucket)
                begin
                    report($sformatf("bucket_start %h, wanted %h", bucket, e.bucket));
                end
                if (status !== e.status)
                begin
                    report($sformatf("error_code %0d, wanted %0d", status, e.status));
                end
            end
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [63:0] time_value;
    logic        out_valid;
    logic        out_ready;
    logic [63:0] bucket_start;
    logic [1:0]  error_code;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [63:0] cfg_data;

    bucket_scoreboard sb;
    bit quiet;      // no idling in the final part
    bit hold_req;   // ask the receiver for a long hold-off
    int idle_count;

    integer_time_bucket DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .time_value   (time_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .bucket_start (bucket_start),
        .error_code   (error_code),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------------
    // Sender and configuration tasks
    // ------------------------------------------------------------------------
    task send_time(logic [63:0] tv);
        int gap;
        gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1'b1;
        time_value <= tv;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note(tv);
    endtask

    // drop valid and let the pipeline empty before touching registers
    task drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (LATENCY) @(posedge clk);
    endtask

    task write_reg(logic [1:0] idx, logic [63:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
        sb.write_reg(idx, data);
    endtask

    task setup(logic [63:0] period, logic [63:0] offset, logic [1:0] mode);
        drain();
        write_reg(itb_pkg::REG_PERIOD, period);
        write_reg(itb_pkg::REG_OFFSET, offset);
        write_reg(itb_pkg::REG_MODE, mode);
    endtask

    function logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // random timestamp: full range, near the edges, or small
    function logic [63:0] rand_time();
        logic [63:0] v;
        case ($urandom_range(0, 5))
            0:       v = 64'h7fff_ffff_ffff_ffff - $urandom_range(0, 40);
            1:       v = 64'h8000_0000_0000_0000 + $urandom_range(0, 40);
            2:       v = {{48{1'b0}}, 16'h7fff} - $urandom_range(0, 40);
            3:       v = 64'($signed(16'h8000)) + $urandom_range(0, 40);
            4:       v = 64'(longint'($urandom_range(0, 2000)) - 1000);
            default: v = rand64();
        endcase
        return v;
    endfunction

    // ------------------------------------------------------------------------
    // Receiver: random stall bursts plus one long hold-off
    // ------------------------------------------------------------------------
    initial
    begin
        int  burst;
        int  hold;
        logic rdy;
        burst = 0;
        hold  = 0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req && hold == 0)
            begin
                hold = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (hold > 0)
            begin
                hold--;
                rdy = 1'b0;
            end
            else if (quiet)
            begin
                rdy = 1'b1;
            end
            else if (burst > 0)
            begin
                burst--;
                rdy = 1'b0;
            end
            else if ($urandom_range(0, 4) == 0)
            begin
                burst = $urandom_range(0, 2);
                rdy = 1'b0;
            end
            else
            begin
                rdy = 1'b1;
            end
            out_ready <= rdy;
        end
    end

    // result check and watchdog
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            sb.check(bucket_start, error_code);
        end
        if ((in_valid && in_ready) || (out_valid && out_ready))
        begin
            idle_count = 0;
        end
        else
        begin
            idle_count++;
            if (idle_count >= IDLE_LIMIT)
            begin
                $display("integer_time_bucket test failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        sb = new();
        quiet      = 1'b0;
        hold_req   = 1'b0;
        idle_count = 0;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        time_value = '0;
        cfg_we     = 1'b0;
        cfg_index  = itb_pkg::REG_PERIOD;
        cfg_data   = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset settings: period 1, identity
        send_time(64'h8000_0000_0000_0000);
        send_time(64'h7fff_ffff_ffff_ffff);
        send_time(64'd0);
        send_time(64'hffff_ffff_ffff_ffff);

        // positive and negative offsets, 64 bits
        setup(64'd7, 64'd3, itb_pkg::MODE_64);
        send_time(64'h8000_0000_0000_0000);     // offset pushes below min
        send_time(64'hffff_ffff_ffff_fffb);     // -5
        send_time(64'd10);
        drain();
        write_reg(itb_pkg::REG_OFFSET, -64'sd3);
        send_time(64'h7fff_ffff_ffff_ffff);     // offset pushes above max
        send_time(64'hffff_ffff_ffff_fff0);

        // non-positive periods
        setup(64'd0, 64'd5, itb_pkg::MODE_32);
        send_time(64'd123);
        setup(-64'sd5, 64'd0, itb_pkg::MODE_64);
        send_time(64'd123);

        // 16 bits: floor step below the minimum, low bits of registers
        setup(64'hffff_0000_0000_4e20, 64'd0, itb_pkg::MODE_16);
        send_time(64'h0000_0000_0000_8000);     // -32768
        send_time(64'h1234_5678_0000_7fff);
        // large period and offset in 16 bits
        setup(64'd30000, 64'd29999, itb_pkg::MODE_16);
        send_time(64'h0000_0000_0000_7fff);
        send_time(64'h0000_0000_0000_7530);

        // 32 bits, unused mode, extreme period and offset, dead index
        setup(64'd100, -64'sd250, itb_pkg::MODE_32);
        send_time(64'hffff_ffff_8000_0000);
        send_time(64'h0000_0000_7fff_ffff);
        setup(64'h7fff_ffff_ffff_ffff, 64'h8000_0000_0000_0000, 2'd3);
        write_reg(2'd3, rand64());
        send_time(64'h8000_0000_0000_0000);
        send_time(64'h7fff_ffff_ffff_ffff);
        send_time(64'd0);

        // random phases; one of them with a long receiver hold-off
        for (int ph = 0; ph < 8; ph++)
        begin
            logic [63:0] per;
            per = ($urandom_range(0, 4) == 0) ? rand64()
                                               : 64'($urandom_range(1, 5000));
            setup(per, ($urandom_range(0, 1) ? rand64() : 64'($urandom_range(0, 9000))),
                  2'($urandom_range(0, 3)));
            if (ph == 7)
            begin
                quiet = 1'b1;
            end
            if (ph == 3)
            begin
                hold_req = 1'b1;
            end
            for (int i = 0; i < 110; i++)
            begin
                send_time(rand_time());
            end
        end

        // let everything drain
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (LATENCY) @(posedge clk);
        if (sb.pending.size() != 0)
        begin
            sb.report("expected items left over");
        end
        if (sb.errors == 0)
        begin
            $display("integer_time_bucket test passed");
        end
        else
        begin
            $display("integer_time_bucket test failed");
        end
        $finish;
    end

endmodule
